>>> rtl/core/ami_pkg.sv
package ami_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IO_WIDTH       = 32;
  localparam int ROW_W          = 2;

  // Row index codes
  localparam logic [ROW_W-1:0] ROW_0    = 2'd0;
  localparam logic [ROW_W-1:0] ROW_1    = 2'd1;
  localparam logic [ROW_W-1:0] ROW_2    = 2'd2;
  localparam logic [ROW_W-1:0] ROW_NONE = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Operand selectors for the shared multiply-accumulate step
  typedef enum logic [1:0] {
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

endpackage

>>> rtl/core/ami_if.sv
interface ami_in_if;
  logic                          valid;
  logic                          ready;
  logic [ami_pkg::ROW_W-1:0]     row_index;
  logic signed [ami_pkg::IO_WIDTH-1:0] col0;
  logic signed [ami_pkg::IO_WIDTH-1:0] col1;
  logic signed [ami_pkg::IO_WIDTH-1:0] col2;
  logic signed [ami_pkg::IO_WIDTH-1:0] col3;
  modport source (output valid, row_index, col0, col1, col2, col3, input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, output ready);
endinterface

interface ami_out_if;
  logic                          valid;
  logic                          ready;
  logic [ami_pkg::ROW_W-1:0]     out_row;
  logic signed [ami_pkg::IO_WIDTH-1:0] inv0;
  logic signed [ami_pkg::IO_WIDTH-1:0] inv1;
  logic signed [ami_pkg::IO_WIDTH-1:0] inv2;
  logic signed [ami_pkg::IO_WIDTH-1:0] inv3;
  logic                          singular;
  logic                          last_row;
  modport source (output valid, out_row, inv0, inv1, inv2, inv3, singular, last_row,
                  input ready);
  modport sink   (input valid, out_row, inv0, inv1, inv2, inv3, singular, last_row,
                  output ready);
endinterface

>>> rtl/core/ami_recip.sv
// Restoring divider: 2^(2F) / |det|, one quotient bit per cycle, then sign and saturate.
module ami_recip #(
  parameter int DATA_WIDTH = ami_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ami_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] det,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] recip
);
  localparam int NB = 2 * FRAC_BITS + 1;   // numerator bits
  localparam int CW = $clog2(NB + 1);
  localparam logic [NB-1:0] NUM = {1'b1, {(NB-1){1'b0}}};
  localparam logic [DATA_WIDTH:0] VMAXU = {2'b00, {(DATA_WIDTH-1){1'b1}}};

  logic [NB-1:0]       num_r, num_nxt;
  logic [DATA_WIDTH:0] rem_r, rem_nxt;
  logic [DATA_WIDTH:0] dvs_r, dvs_nxt;
  logic [NB-1:0]       quo_r, quo_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, neg_r, neg_nxt;
  logic                done_r, done_nxt;
  logic [DATA_WIDTH+1:0] trial;
  logic [DATA_WIDTH:0]   shifted;
  logic signed [DATA_WIDTH:0] det_x;

  always_comb begin
    det_x    = {det[DATA_WIDTH-1], det};
    shifted  = {rem_r[DATA_WIDTH-1:0], num_r[NB-1]};
    trial    = {1'b0, shifted} - {1'b0, dvs_r};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = NUM;
      rem_nxt  = '0;
      dvs_nxt  = det[DATA_WIDTH-1] ? (~det_x + 1'b1) : det_x;
      quo_nxt  = '0;
      cnt_nxt  = CW'(NB);
      busy_nxt = 1'b1;
      neg_nxt  = det[DATA_WIDTH-1];
    end else if (busy_r) begin
      num_nxt = {num_r[NB-2:0], 1'b0};
      if (!trial[DATA_WIDTH+1]) begin
        rem_nxt = trial[DATA_WIDTH:0];
        quo_nxt = {quo_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  // Quotient is at most 2^(2F); saturate to the data range with sign.
  logic [NB:0] qx;
  always_comb begin
    qx = {1'b0, quo_r};
    if (neg_r) begin
      if (qx > (NB+1)'(VMAXU) + 1'b1) recip = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      else recip = DATA_WIDTH'(~qx + 1'b1);
    end else begin
      if (qx > (NB+1)'(VMAXU)) recip = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      else recip = DATA_WIDTH'(qx);
    end
  end
  assign done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> busy_r || done_r) else $error("divider dropped busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0) else $error("divider count mismatch");
endmodule

>>> rtl/core/affine_matrix_inverse_core.sv
// Affine 3x4 matrix inverse, signed fixed point (DATA_WIDTH bits, FRAC_BITS
// fraction). Send rows 0 and 1 (stored, no result), then row 2, which starts
// the inversion; three result items follow, rows 0..2, last_row on the third.
// Row index 3 is dropped. A zero determinant gives the identity with singular
// set. For row 2, one shared multiply/add-subtract unit runs a 43-step
// microprogram (cofactors, determinant, adjugate scaled by 1/det, translation),
// one step per cycle except while it waits on the restoring divider for 1/det.
// A zero determinant is caught after step 9, so the identity rows follow
// without the divide. Each result then waits only on out_ch.ready. The block
// is not ready from acceptance of row 2 until its third result is taken.
// All intermediates saturate to DATA_WIDTH; outputs saturate to 32 bits.
module affine_matrix_inverse_core #(
  parameter int DATA_WIDTH = ami_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ami_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ami_in_if.sink        in_ch,
  ami_out_if.source     out_ch
);
  localparam int DW = DATA_WIDTH;
  localparam int IW = ami_pkg::IO_WIDTH;
  localparam int PW = 2 * DW;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = (FRAC_BITS < DW-1) ?
                                          DW'(64'sd1 <<< FRAC_BITS) : VMAX;

  // Register file: 0..11 matrix m[i][j] at i*4+j, 12.. temporaries.
  // m[0..1] come from the stored rows 0 and 1, m[2] from the row 2 input.
  // Slots: 12 c0, 13 c1, 14 c2, 15 d, 16 det, 17..28 result r[i][j] at 17+i*4+j,
  // except r[0][3], which is at 29 (slot 20 is unused).
  localparam int NREG = 30;
  logic signed [DW-1:0] rf_r [NREG];

  ami_pkg::state_t state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic [1:0] emit_r, emit_nxt;
  logic       sing_r, sing_nxt;

  // ---------------- input conversion ----------------
  function automatic logic signed [DW-1:0] from_io(input logic signed [IW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > 64'(VMAX)) return VMAX;
    if (w < 64'(VMIN)) return VMIN;
    return DW'(w);
  endfunction

  function automatic logic signed [IW-1:0] to_io(input logic signed [DW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > 64'sd2147483647) return 32'sh7fffffff;
    if (w < -64'sd2147483648) return 32'sh80000000;
    return IW'(w);
  endfunction

  // ---------------- microprogram ----------------
  // op ACC_LOAD: acc = a*b. ACC_SUB: acc = acc - a*b. ACC_ADD: acc = acc + a*b.
  // wr stores the accumulator (after this step) into dst.
  // a and b are register file slots; b of K_ONE multiplies by one (a copy).
  typedef struct packed {
    logic [4:0]       a;
    logic [4:0]       b;   // 31 means the value of one (for copies)
    ami_pkg::acc_op_t op;
    logic             wr;
    logic [4:0]       dst;
  } uop_t;

  localparam logic [4:0] K_ONE = 5'd31;

  function automatic uop_t prog(input logic [5:0] pc);
    uop_t u;
    u = '{5'd0, 5'd0, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
    case (pc)
      6'd0:  u = '{5'd5,  5'd10, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd1:  u = '{5'd6,  5'd9,  ami_pkg::ACC_SUB,  1'b1, 5'd12};
      6'd2:  u = '{5'd4,  5'd10, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd3:  u = '{5'd6,  5'd8,  ami_pkg::ACC_SUB,  1'b1, 5'd13};
      6'd4:  u = '{5'd4,  5'd9,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd5:  u = '{5'd5,  5'd8,  ami_pkg::ACC_SUB,  1'b1, 5'd14};
      // det = m00*c0 - m01*c1 + m02*c2
      6'd6:  u = '{5'd0,  5'd12, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd7:  u = '{5'd1,  5'd13, ami_pkg::ACC_SUB,  1'b0, 5'd0};
      6'd8:  u = '{5'd2,  5'd14, ami_pkg::ACC_ADD,  1'b1, 5'd16};
      // adjugate entries (unscaled) into r slots; after divide they get * d
      6'd9:  u = '{5'd12, K_ONE, ami_pkg::ACC_LOAD, 1'b1, 5'd17};
      6'd10: u = '{5'd2,  5'd9,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd11: u = '{5'd1,  5'd10, ami_pkg::ACC_SUB,  1'b1, 5'd18};
      6'd12: u = '{5'd1,  5'd6,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd13: u = '{5'd2,  5'd5,  ami_pkg::ACC_SUB,  1'b1, 5'd19};
      6'd14: u = '{5'd6,  5'd8,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd15: u = '{5'd4,  5'd10, ami_pkg::ACC_SUB,  1'b1, 5'd21};
      6'd16: u = '{5'd0,  5'd10, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd17: u = '{5'd2,  5'd8,  ami_pkg::ACC_SUB,  1'b1, 5'd22};
      6'd18: u = '{5'd2,  5'd4,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd19: u = '{5'd0,  5'd6,  ami_pkg::ACC_SUB,  1'b1, 5'd23};
      6'd20: u = '{5'd14, K_ONE, ami_pkg::ACC_LOAD, 1'b1, 5'd25};
      6'd21: u = '{5'd1,  5'd8,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd22: u = '{5'd0,  5'd9,  ami_pkg::ACC_SUB,  1'b1, 5'd26};
      6'd23: u = '{5'd0,  5'd5,  ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd24: u = '{5'd1,  5'd4,  ami_pkg::ACC_SUB,  1'b1, 5'd27};
      // --- divider runs between pc 24 and 25 ---
      6'd25: u = '{5'd17, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd17};
      6'd26: u = '{5'd18, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd18};
      6'd27: u = '{5'd19, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd19};
      6'd28: u = '{5'd21, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd21};
      6'd29: u = '{5'd22, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd22};
      6'd30: u = '{5'd23, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd23};
      6'd31: u = '{5'd25, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd25};
      6'd32: u = '{5'd26, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd26};
      6'd33: u = '{5'd27, 5'd15, ami_pkg::ACC_LOAD, 1'b1, 5'd27};
      // t' = -(m03*r[i][0] + m13*r[i][1] + m23*r[i][2]); sum here, negated on write
      6'd34: u = '{5'd3,  5'd17, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd35: u = '{5'd7,  5'd18, ami_pkg::ACC_ADD,  1'b0, 5'd0};
      6'd36: u = '{5'd11, 5'd19, ami_pkg::ACC_ADD,  1'b1, 5'd29};
      6'd37: u = '{5'd3,  5'd21, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd38: u = '{5'd7,  5'd22, ami_pkg::ACC_ADD,  1'b0, 5'd0};
      6'd39: u = '{5'd11, 5'd23, ami_pkg::ACC_ADD,  1'b1, 5'd24};
      6'd40: u = '{5'd3,  5'd25, ami_pkg::ACC_LOAD, 1'b0, 5'd0};
      6'd41: u = '{5'd7,  5'd26, ami_pkg::ACC_ADD,  1'b0, 5'd0};
      6'd42: u = '{5'd11, 5'd27, ami_pkg::ACC_ADD,  1'b1, 5'd28};
      default: u = u;
    endcase
    return u;
  endfunction

  localparam logic [5:0] PC_DIV  = 6'd25;
  localparam logic [5:0] PC_LAST = 6'd42;
  localparam logic [5:0] PC_DETW = 6'd8;

  // ---------------- shared multiply/accumulate unit ----------------
  // One step per cycle while in ST_MUL: product, floor shift, saturate, accumulate.
  uop_t u;
  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   prod_sh;
  logic signed [DW-1:0] prod_sat;
  logic signed [DW-1:0] acc_r, acc_nxt;
  logic signed [DW:0]   sum;

  always_comb begin
    u    = prog(pc_r);
    opa  = rf_r[u.a];
    opb  = (u.b == K_ONE) ? ONE : rf_r[u.b];
  end

  // floor shift: arithmetic shift of the exact product is floor
  always_comb begin
    prod    = PW'(opa) * PW'(opb);
    prod_sh = (PW+1)'(prod) >>> FRAC_BITS;
    if (prod_sh > (PW+1)'(VMAX))      prod_sat = VMAX;
    else if (prod_sh < (PW+1)'(VMIN)) prod_sat = VMIN;
    else                              prod_sat = DW'(prod_sh);
  end

  always_comb begin
    unique case (u.op)
      ami_pkg::ACC_SUB: sum = (DW+1)'(acc_r) - (DW+1)'(prod_sat);
      ami_pkg::ACC_ADD: sum = (DW+1)'(acc_r) + (DW+1)'(prod_sat);
      default:          sum = (DW+1)'(prod_sat);
    endcase
    if (sum > (DW+1)'(VMAX))      acc_nxt = VMAX;
    else if (sum < (DW+1)'(VMIN)) acc_nxt = VMIN;
    else                          acc_nxt = DW'(sum);
  end

  // ---------------- divider ----------------
  logic                  div_start, div_done;
  logic signed [DW-1:0]  recip;

  ami_recip #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .det   (rf_r[16]),
    .done  (div_done),
    .recip (recip)
  );

  // ---------------- sequencer ----------------
  logic in_fire, out_fire, run_step;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    emit_nxt  = emit_r;
    sing_nxt  = sing_r;
    unique case (state_r)
      ami_pkg::ST_IDLE: begin
        if (in_fire && in_ch.row_index == ami_pkg::ROW_2) begin
          state_nxt = ami_pkg::ST_MUL;
          pc_nxt    = '0;
        end
      end
      ami_pkg::ST_MUL: begin
        pc_nxt = pc_r + 1'b1;
        if (pc_r == PC_DETW + 1'b1 && rf_r[16] == '0) begin
          sing_nxt  = 1'b1;
          state_nxt = ami_pkg::ST_EMIT;
          emit_nxt  = '0;
        end else if (pc_r == PC_DETW + 1'b1) begin
          sing_nxt = 1'b0;
        end
        if (pc_r == PC_DIV - 1'b1) state_nxt = ami_pkg::ST_DIV;
        if (pc_r == PC_LAST) begin
          state_nxt = ami_pkg::ST_EMIT;
          emit_nxt  = '0;
        end
      end
      ami_pkg::ST_DIV: begin
        if (div_done) state_nxt = ami_pkg::ST_MUL;
      end
      ami_pkg::ST_EMIT: begin
        if (out_fire) begin
          emit_nxt = emit_r + 1'b1;
          if (emit_r == ami_pkg::ROW_2) state_nxt = ami_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ami_pkg::ST_IDLE;
    endcase
  end

  assign run_step  = (state_r == ami_pkg::ST_MUL);
  // det is written at pc 8; start the divide when entering ST_DIV.
  // A singular matrix leaves at pc 9 and never gets here.
  assign div_start = run_step && (pc_r == PC_DIV - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ami_pkg::ST_IDLE;
      pc_r    <= '0;
      emit_r  <= '0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      emit_r  <= emit_nxt;
      sing_r  <= sing_nxt;
    end
  end

  // ---------------- register file ----------------
  always_ff @(posedge clk) begin
    if (in_fire && state_r == ami_pkg::ST_IDLE) begin
      unique case (in_ch.row_index)
        ami_pkg::ROW_0: begin
          rf_r[0] <= from_io(in_ch.col0); rf_r[1] <= from_io(in_ch.col1);
          rf_r[2] <= from_io(in_ch.col2); rf_r[3] <= from_io(in_ch.col3);
        end
        ami_pkg::ROW_1: begin
          rf_r[4] <= from_io(in_ch.col0); rf_r[5] <= from_io(in_ch.col1);
          rf_r[6] <= from_io(in_ch.col2); rf_r[7] <= from_io(in_ch.col3);
        end
        ami_pkg::ROW_2: begin
          rf_r[8]  <= from_io(in_ch.col0); rf_r[9]  <= from_io(in_ch.col1);
          rf_r[10] <= from_io(in_ch.col2); rf_r[11] <= from_io(in_ch.col3);
        end
        default: ;
      endcase
    end
    if (run_step) begin
      acc_r <= acc_nxt;
      // translation slots hold the negated sum
      if (u.wr) begin
        if (u.dst == 5'd29 || u.dst == 5'd24 || u.dst == 5'd28)
          rf_r[u.dst] <= (acc_nxt == VMIN) ? VMAX : -acc_nxt;
        else
          rf_r[u.dst] <= acc_nxt;
      end
    end
    if (state_r == ami_pkg::ST_DIV && div_done) rf_r[15] <= recip;
  end

  // ---------------- output ----------------
  logic signed [DW-1:0] o0, o1, o2, o3;
  always_comb begin
    o0 = rf_r[17]; o1 = rf_r[18]; o2 = rf_r[19]; o3 = rf_r[29];
    case (emit_r)
      ami_pkg::ROW_1: begin o0 = rf_r[21]; o1 = rf_r[22]; o2 = rf_r[23]; o3 = rf_r[24]; end
      ami_pkg::ROW_2: begin o0 = rf_r[25]; o1 = rf_r[26]; o2 = rf_r[27]; o3 = rf_r[28]; end
      default: ;
    endcase
    if (sing_r) begin
      o0 = (emit_r == ami_pkg::ROW_0) ? ONE : '0;
      o1 = (emit_r == ami_pkg::ROW_1) ? ONE : '0;
      o2 = (emit_r == ami_pkg::ROW_2) ? ONE : '0;
      o3 = '0;
    end
  end

  assign in_ch.ready     = (state_r == ami_pkg::ST_IDLE);
  assign out_ch.valid    = (state_r == ami_pkg::ST_EMIT);
  assign out_ch.out_row  = emit_r;
  assign out_ch.inv0     = to_io(o0);
  assign out_ch.inv1     = to_io(o1);
  assign out_ch.inv2     = to_io(o2);
  assign out_ch.inv3     = to_io(o3);
  assign out_ch.singular = sing_r;
  assign out_ch.last_row = (emit_r == ami_pkg::ROW_2);

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while emitting");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> emit_r != ami_pkg::ROW_NONE) else $error("bad emit row");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_row |=> state_r == ami_pkg::ST_IDLE)
    else $error("no idle after last row");
  a_start_compute: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.row_index == ami_pkg::ROW_2 |=> state_r == ami_pkg::ST_MUL)
    else $error("row 2 did not start compute");
endmodule
